// ===== sv/double_hash_open_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double hashing open table unit.
// Each macro checks an implication at every rising clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_OPEN_TABLE_UNIT_ASSERT_SVH
`define DOUBLE_HASH_OPEN_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHOT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("double hash table unit: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DHOT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("double hash table unit: assertion failed");

`endif

// ===== sv/dhot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhot_pkg
// Shared types and codes of the double hashing open table unit.
// ----------------------------------------------------------------------------
package dhot_pkg;

  localparam int SIZE_W = 7;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int SLOT_W = 6;
  localparam int OUTC_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEL  = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_INSERTED   = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_DELETED    = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_NOT_FOUND  = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_TABLE_FULL = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot_index;
    logic [SIZE_W-1:0] probe_count;
  } out_res_t;

  // Remainders of the key by m and by m - 2.
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem_m;
    logic [SIZE_W-1:0] rem_m2;
  } mod_res_t;

  typedef struct packed {
    logic     valid;
    out_res_t res;
  } eng_res_t;

endpackage

// ===== sv/dhot_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhot_mod
// Bit-serial remainder unit: key mod m and key mod (m - 2), one key bit a cycle.
// ----------------------------------------------------------------------------
module dhot_mod #(
  parameter int KW = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [KW-1:0]               key,
  input  logic [dhot_pkg::SIZE_W-1:0] m,
  output dhot_pkg::mod_res_t          res
);
  import dhot_pkg::*;

  localparam int CW = $clog2(KW + 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [SIZE_W-1:0] ra_r, ra_nxt;
  logic [SIZE_W-1:0] rb_r, rb_nxt;
  logic [SIZE_W-1:0] m2;

  // Shift one dividend bit into a partial remainder and reduce once.
  function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
                                                 input logic b,
                                                 input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SIZE_W-1:0];
  endfunction

  assign m2 = m - SIZE_W'(2);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    key_nxt  = key_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(KW);
      key_nxt = key;
      ra_nxt  = '0;
      rb_nxt  = '0;
    end else if (run_r) begin
      ra_nxt  = rem_step(ra_r, key_r[KW-1], m);
      rb_nxt  = rem_step(rb_r, key_r[KW-1], m2);
      key_nxt = {key_r[KW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
  end

  assign res.done   = done_r;
  assign res.rem_m  = ra_r;
  assign res.rem_m2 = rb_r;

endmodule

// ===== sv/dhot_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhot_engine
// Slot memory and probe sequencer: clears the table, then walks the probe
// sequence with one read per probe and at most one write-back per request.
// ----------------------------------------------------------------------------
module dhot_engine #(
  parameter int TABLE_DEPTH = 64,
  parameter int KW          = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  dhot_pkg::in_req_t           in_req,
  input  logic [dhot_pkg::SIZE_W-1:0] m,
  input  dhot_pkg::mod_res_t          mod_res,
  output logic                        busy,
  output dhot_pkg::eng_res_t          eng_res
);
  import dhot_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int WW = 2 + KW + VAL_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              op_r, op_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [SIZE_W-1:0] pos_r, pos_nxt;
  logic [SIZE_W-1:0] step_r, step_nxt;
  logic [SIZE_W-1:0] idx_r, idx_nxt;

  logic [WW-1:0]     mem [TABLE_DEPTH];
  logic [WW-1:0]     rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WW-1:0]     wdata;

  logic [1:0]        rd_st;
  logic [KW-1:0]     rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic              hit_ins, hit_free, hit_del, last;
  logic [SIZE_W-1:0] probes;
  logic [SIZE_W:0]   pos_sum;

  assign rd_st  = rdata_r[WW-1 -: 2];
  assign rd_key = rdata_r[VAL_W +: KW];
  assign rd_val = rdata_r[VAL_W-1:0];

  assign hit_ins  = (op_r == OP_INSERT) && (rd_st != ST_FULL);
  assign hit_free = (op_r == OP_DELETE) && (rd_st == ST_FREE);
  assign hit_del  = (op_r == OP_DELETE) && (rd_st == ST_FULL) && (rd_key == key_r);
  assign probes   = idx_r + SIZE_W'(1);
  assign last     = (probes == m);
  assign pos_sum  = {1'b0, pos_r} + {1'b0, step_r};

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    we        = 1'b0;
    waddr     = AW'(pos_r);
    wdata     = {ST_FREE, {(KW + VAL_W){1'b0}}};
    eng_res   = '0;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_req.opcode;
          key_nxt   = in_req.key[KW-1:0];
          val_nxt   = in_req.value;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_res.done) begin
          pos_nxt   = mod_res.rem_m;
          step_nxt  = mod_res.rem_m2 + SIZE_W'(1);
          idx_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (hit_ins) begin
          we    = 1'b1;
          wdata = {ST_FULL, key_r, val_r};
        end else if (hit_del) begin
          we    = 1'b1;
          wdata = {ST_DEL, rd_key, rd_val};
        end
        if (hit_ins || hit_free || hit_del || last) begin
          eng_res.valid           = 1'b1;
          eng_res.res.probe_count = probes;
          if (hit_ins) begin
            eng_res.res.outcome    = OUT_INSERTED;
            eng_res.res.slot_index = pos_r[SLOT_W-1:0];
          end else if (hit_del) begin
            eng_res.res.outcome    = OUT_DELETED;
            eng_res.res.slot_index = pos_r[SLOT_W-1:0];
          end else if (op_r == OP_INSERT) begin
            eng_res.res.outcome = OUT_TABLE_FULL;
          end else begin
            eng_res.res.outcome = OUT_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end else begin
          if (pos_sum >= {1'b0, m}) begin
            pos_nxt = SIZE_W'(pos_sum - {1'b0, m});
          end else begin
            pos_nxt = pos_sum[SIZE_W-1:0];
          end
          idx_nxt   = probes;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[AW'(pos_r)];
  end

endmodule

// ===== sv/double_hash_open_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_table_unit
// Open-addressing hash table with double hashing, insert and delete requests.
// ----------------------------------------------------------------------------
// After reset the unit holds busy high while a clearing pass marks every
// slot free; configuration writes are taken during that time.
// A request is taken when start is high and busy is low. It first passes
// through the bit-serial remainder unit, which forms key mod m and key mod
// (m - 2) together, and then, for each probe, reads the slot memory, whose
// read data is registered, and examines the slot and writes it back. A
// request keeps busy high while it is in flight, and start is taken again
// in the cycle busy falls. The result appears with out_valid the cycle after
// the last probe and is on the ports for that single cycle only: the
// receiver cannot stall, so it must take every strobe. Here m is the
// configured table size held to the range from three to TABLE_DEPTH (and at
// most 127). A new table size keeps the stored contents; slots at or beyond
// the new size are simply not probed. Write it only while the unit is idle
// and no result is still due.
// ----------------------------------------------------------------------------
`include "double_hash_open_table_unit_assert.svh"

module double_hash_open_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  dhot_pkg::in_req_t           in_req,
  input  logic                        cfg_we,
  input  logic [dhot_pkg::SIZE_W-1:0] cfg_wdata,
  output logic                        out_valid,
  output dhot_pkg::out_res_t          out_res
);
  import dhot_pkg::*;

  // Stored key width: key bits above KEY_WIDTH are ignored.
  localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;

  // Largest usable table size: the memory depth, capped by the register range.
  localparam int                DEPTH_CAP   = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
  localparam logic [SIZE_W-1:0] DEPTH_CAP_W = SIZE_W'(DEPTH_CAP);
  localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] RESET_SIZE  = SIZE_W'(64);

  logic [SIZE_W-1:0] table_size_r, table_size_nxt;
  logic              out_valid_r;
  out_res_t          out_res_r;
  logic              accept;
  mod_res_t          mod_res;
  eng_res_t          eng_res;

  // The table size register holds the active modulus, already clamped, so
  // that the hash and probe logic never sees a size below three.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (r < MIN_SIZE) begin
      r = MIN_SIZE;
    end
    if (r > DEPTH_CAP_W) begin
      r = DEPTH_CAP_W;
    end
    return r;
  endfunction

  assign accept = start && !busy;

  always_comb begin
    table_size_nxt = table_size_r;
    if (cfg_we) begin
      table_size_nxt = clamp_size(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= clamp_size(RESET_SIZE);
      out_valid_r  <= 1'b0;
    end else begin
      table_size_r <= table_size_nxt;
      out_valid_r  <= eng_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= eng_res.res;
  end

  // Both hash remainders are formed at once, one key bit per cycle.
  dhot_mod #(
    .KW (KW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_req.key[KW-1:0]),
    .m     (table_size_r),
    .res   (mod_res)
  );

  // Slot memory, clearing pass and probe walk.
  dhot_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KW          (KW)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_req  (in_req),
    .m       (table_size_r),
    .mod_res (mod_res),
    .busy    (busy),
    .eng_res (eng_res)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A taken request keeps the unit busy until its result is formed.
  `DHOT_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  // A result only follows a request in flight.
  `DHOT_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy))
  // The probe count lies between one and the active table size.
  `DHOT_ASSERT_IMP(a_probe_range, clk, rst_n, out_valid, (out_res.probe_count != '0) && (out_res.probe_count <= table_size_r))
  // A full table reports no slot and a complete probe sequence.
  `DHOT_ASSERT_IMP(a_full_no_slot, clk, rst_n, out_valid && (out_res.outcome == OUT_TABLE_FULL), (out_res.slot_index == '0) && (out_res.probe_count == table_size_r))

endmodule

// ===== tb/double_hash_open_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_table_unit_tb
// Self-checking bench for the double hashing open table unit. Insert and delete
// requests come from a queue and are driven in random bursts. A shadow copy of
// the slot table predicts every result, and each result strobe is compared
// field by field with the oldest prediction. The table size register is
// rewritten between phases and sweeps its extremes, including the clamped values.
// ----------------------------------------------------------------------------
module double_hash_open_table_unit_tb;
  import dhot_pkg::*;

  localparam int DEPTH     = 64;
  localparam int POOL_SIZE = 24;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  logic     busy;
  in_req_t  in_req    = '0;
  logic     cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic     out_valid;
  out_res_t out_res;

  double_hash_open_table_unit #(
    .TABLE_DEPTH(DEPTH),
    .KEY_WIDTH  (KEY_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The run is bounded by a fixed time. The slowest legal run, about 850
  // requests, each at its longest busy time plus the longest gap, is about a
  // seventh of this.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow table. It mirrors the slot status, key and table size registers and
  // is updated in the order in which the block accepts requests.
  // --------------------------------------------------------------------------
  logic [1:0]        shadow_status [DEPTH];
  logic [KEY_W-1:0]  shadow_key    [DEPTH];
  logic [SIZE_W-1:0] shadow_size;

  // Computes the result of one insert or delete request and applies it to the
  // shadow table. The probe sequence is (k mod m + i * (1 + k mod (m - 2))) mod m.
  function automatic out_res_t apply_table_op(in_req_t req);
    int unsigned m;
    int unsigned pos;
    int unsigned stride;
    int unsigned i;
    logic        hit;
    out_res_t    res;
    m = shadow_size;
    // Sizes below three are taken as three and sizes above the depth saturate.
    if (m < 3) m = 3;
    if (m > DEPTH) m = DEPTH;
    pos    = req.key % m;
    stride = 1 + req.key % (m - 2);
    res.outcome     = (req.opcode == OP_INSERT) ? OUT_TABLE_FULL : OUT_NOT_FOUND;
    res.slot_index  = '0;
    res.probe_count = SIZE_W'(m);
    hit = 1'b0;
    for (i = 0; i < m && !hit; i++) begin
      if (req.opcode == OP_INSERT) begin
        // A free or a deleted slot is taken; duplicate keys are not checked.
        if (shadow_status[pos] != ST_FULL) begin
          shadow_status[pos] = ST_FULL;
          shadow_key[pos]    = req.key;
          res.outcome        = OUT_INSERTED;
          res.slot_index     = SLOT_W'(pos);
          res.probe_count    = SIZE_W'(i + 1);
          hit                = 1'b1;
        end
      end else begin
        if (shadow_status[pos] == ST_FREE) begin
          res.outcome     = OUT_NOT_FOUND;
          res.probe_count = SIZE_W'(i + 1);
          hit             = 1'b1;
        end else if (shadow_status[pos] == ST_FULL && shadow_key[pos] == req.key) begin
          shadow_status[pos] = ST_DEL;
          res.outcome        = OUT_DELETED;
          res.slot_index     = SLOT_W'(pos);
          res.probe_count    = SIZE_W'(i + 1);
          hit                = 1'b1;
        end
      end
      if (!hit) begin
        pos = pos + stride;
        if (pos >= m) pos = pos - m;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. A result strobe at the
  // same edge as an acceptance belongs to an earlier request, so the check is
  // done before the new prediction is queued.
  // --------------------------------------------------------------------------
  out_res_t  due_results [$];
  out_res_t  oldest_due;
  logic      accepted_q   = 1'b0;
  int        taken_count  = 0;
  int        error_count  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      accepted_q  <= 1'b0;
      shadow_size = SIZE_W'(DEPTH);
      for (int s = 0; s < DEPTH; s++) begin
        shadow_status[s] = ST_FREE;
        shadow_key[s]    = '0;
      end
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result strobe with no request outstanding: outcome %0d slot %0d probes %0d",
                 out_res.outcome, out_res.slot_index, out_res.probe_count);
          error_count++;
        end else begin
          oldest_due = due_results.pop_front();
          if (out_res.outcome !== oldest_due.outcome) begin
            $error("outcome: expected %0d, got %0d", oldest_due.outcome, out_res.outcome);
            error_count++;
          end
          if (out_res.slot_index !== oldest_due.slot_index) begin
            $error("slot_index: expected %0d, got %0d",
                   oldest_due.slot_index, out_res.slot_index);
            error_count++;
          end
          if (out_res.probe_count !== oldest_due.probe_count) begin
            $error("probe_count: expected %0d, got %0d",
                   oldest_due.probe_count, out_res.probe_count);
            error_count++;
          end
        end
      end
      if (cfg_we) shadow_size = cfg_wdata;
      if (start && !busy) begin
        due_results.push_back(apply_table_op(in_req));
        taken_count++;
      end
      accepted_q <= start && !busy;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. Requests leave the queue at the falling edge in bursts of random
  // length separated by random gaps. A request stays on the port, with start
  // high, until the monitor has seen it accepted.
  // --------------------------------------------------------------------------
  in_req_t queued_ops [$];
  in_req_t next_op;
  int      queued_count = 0;
  int      burst_left   = 1;
  int      gap_left     = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accepted_q) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (queued_ops.size() > 0) begin
        next_op = queued_ops.pop_front();
        in_req <= next_op;
        start  <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Long bursts give stretches with no idling; the gaps reach past the
          // longest request so that they land on every stage of the work.
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  task automatic queue_op(input logic opcode, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    in_req_t req;
    req.opcode = opcode;
    req.key    = key;
    req.value  = value;
    queued_ops.push_back(req);
    queued_count++;
  endtask

  // Idle means every queued request was accepted, every result has arrived
  // and the block has dropped busy.
  task automatic wait_idle();
    do @(negedge clk);
    while (!(taken_count == queued_count && due_results.size() == 0 && !busy));
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] size);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    // Half the pool is small keys that collide often, half spans all key bits.
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, 300));
    return KEY_W'($urandom());
  endfunction

  task automatic queue_random_phase(input int count);
    int insert_pct;
    logic [KEY_W-1:0] key;
    insert_pct = $urandom_range(45, 85);
    for (int j = 0; j < 8; j++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
    for (int j = 0; j < count; j++) begin
      // Mostly pool keys, so deletes find what earlier inserts stored.
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : KEY_W'($urandom());
      queue_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE, key,
               VAL_W'($urandom()));
    end
  endtask

  logic [SIZE_W-1:0] phase_sizes [8] = '{7'd3, 7'd5, 7'd17, 7'd64, 7'd100, 7'd40, 7'd2, 7'd64};

  initial begin
    for (int j = 0; j < POOL_SIZE; j++) key_pool[j] = fresh_key();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Full size: the key extremes, a collision on the first hash, a duplicate
    // insert, deletes that walk over deleted slots, and reuse of a deleted slot.
    write_table_size(7'd64);
    queue_op(OP_INSERT, '0, 32'h8000_0000);
    queue_op(OP_INSERT, {KEY_W{1'b1}}, 32'h7FFF_FFFF);
    queue_op(OP_INSERT, KEY_W'(64), 32'h0000_0000);
    queue_op(OP_INSERT, '0, 32'hFFFF_FFFF);
    queue_op(OP_DELETE, '0, 32'h0000_0000);
    queue_op(OP_DELETE, '0, 32'hFFFF_FFFF);
    queue_op(OP_DELETE, '0, 32'h1234_5678);
    queue_op(OP_DELETE, KEY_W'(12345), 32'h0000_0000);
    queue_op(OP_INSERT, KEY_W'(128), 32'h5A5A_A5A5);

    // A size below three is held at three; stored contents are kept. This
    // fills the table, so two inserts report table full and a delete of an
    // absent key probes every slot.
    write_table_size(7'd1);
    queue_op(OP_INSERT, KEY_W'(5), 32'h0000_0001);
    queue_op(OP_INSERT, KEY_W'(6), 32'h0000_0002);
    queue_op(OP_INSERT, KEY_W'(7), 32'h0000_0003);
    queue_op(OP_INSERT, KEY_W'(9), 32'h0000_0004);
    queue_op(OP_DELETE, KEY_W'(1000), 32'h0000_0000);
    queue_op(OP_DELETE, KEY_W'(6), 32'h0000_0000);
    queue_op(OP_INSERT, KEY_W'(6), 32'hDEAD_BEEF);

    write_table_size(7'd0);
    queue_op(OP_DELETE, KEY_W'(128), 32'h0000_0000);
    queue_op(OP_INSERT, {KEY_W{1'b1}}, 32'h0F0F_0F0F);

    // A size above the depth saturates; the entry in the top slot written
    // under the full size is still there.
    write_table_size(7'd127);
    queue_op(OP_DELETE, {KEY_W{1'b1}}, 32'h0000_0000);
    queue_op(OP_DELETE, KEY_W'(64), 32'h0000_0000);
    queue_op(OP_INSERT, KEY_W'(1), 32'hF0F0_F0F0);

    for (int p = 0; p < 8; p++) begin
      write_table_size(phase_sizes[p]);
      queue_random_phase(103);
    end

    wait_idle();
    // Any stray strobe after the last result is caught by the monitor here.
    repeat (200) @(negedge clk);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
